// ===== rtl/core/hfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfd_pkg
// Types and constants shared by the Huffman tree decoder: node entry layout,
// command and error codes, result record and controller states.
// ----------------------------------------------------------------------------
package hfd_pkg;

   // tree sizing
   localparam int NODE_DEPTH   = 512;
   localparam int ADDR_W       = $clog2(NODE_DEPTH);
   localparam int USED_W       = $clog2(NODE_DEPTH + 1);
   localparam int MAX_CODE_LEN = 32;

   // field widths
   localparam int SYM_W  = 8;
   localparam int CODE_W = 32;
   localparam int LEN_W  = 6;
   localparam int DATA_W = 8;
   localparam int BCNT_W = 4;
   localparam int SHIFT_W = $clog2(CODE_W);

   // width of the fit check sum (nodes in use plus nodes still needed)
   localparam int FIT_W = ((USED_W > LEN_W) ? USED_W : LEN_W) + 1;

   // commands
   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_ADD    = 2'd1,
      CMD_DECODE = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   // error codes
   typedef enum logic [1:0] {
      ERR_NONE   = 2'd0,
      ERR_LENGTH = 2'd1,
      ERR_FULL   = 2'd2,
      ERR_BRANCH = 2'd3
   } err_type;

   // one node of the tree: a zero link means no child
   typedef struct packed {
      logic [SYM_W-1:0]  sym;
      logic [ADDR_W-1:0] right;
      logic [ADDR_W-1:0] left;
   } entry_type;

   // root node links, kept in flip-flops
   typedef struct packed {
      logic [ADDR_W-1:0] right;
      logic [ADDR_W-1:0] left;
   } links_type;

   // one result record
   typedef struct packed {
      logic [SYM_W-1:0] sym;
      logic             valid;
      err_type          err;
   } result_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_MAKE,
      ST_DECODE,
      ST_DONE
   } state_type;

endpackage

// ===== rtl/core/huffman_tree_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_tree_decoder
// Huffman decoder that walks a binary code tree held in a node memory.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; busy stays high
// until the cycle in which the last result appears. Results come on
// rsp_strobe and cannot be held off, so a receiver must take each on the
// cycle it appears. An add first reads down the existing path, then writes
// the new link and one new node a cycle, the symbol in the last node. A
// decode walks at most min(bit_count, 8) bits and stops early when a branch
// is missing: each bit needs one dependent node-memory read, and each leaf
// reached takes an extra step to return to the root. The root node lives in
// flip-flops and every other node is written when allocated before it can
// be read, so reset and clear are immediate and the memory needs no clearing
// pass. One result is held back in a pending register so the final one can
// be marked with rsp_last_of_item.
// ----------------------------------------------------------------------------
module huffman_tree_decoder (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_command,
   input  logic [hfd_pkg::SYM_W-1:0]         req_symbol,
   input  logic [hfd_pkg::LEN_W-1:0]         req_code_length,
   input  logic [hfd_pkg::CODE_W-1:0]        req_code_bits,
   input  logic [hfd_pkg::DATA_W-1:0]        req_data_byte,
   input  logic [hfd_pkg::BCNT_W-1:0]        req_bit_count,
   output logic                              rsp_strobe,
   output logic [hfd_pkg::SYM_W-1:0]         rsp_decoded_symbol,
   output logic                              rsp_symbol_valid,
   output logic                              rsp_last_of_item,
   output logic [1:0]                        rsp_error_code
);

   // node memory
   hfd_pkg::entry_type mem [hfd_pkg::NODE_DEPTH];
   hfd_pkg::entry_type rdata_ff;
   logic [hfd_pkg::ADDR_W-1:0] raddr;
   logic                       wr_en;
   logic [hfd_pkg::ADDR_W-1:0] waddr;
   hfd_pkg::entry_type         wdata;

   // control and datapath registers
   hfd_pkg::state_type          state_ff, state_in;
   logic [hfd_pkg::USED_W-1:0]  nu_ff, nu_in;
   logic [hfd_pkg::ADDR_W-1:0]  cur_ff, cur_in;
   logic [hfd_pkg::ADDR_W-1:0]  walk_ff, walk_in;
   hfd_pkg::links_type          root_ff, root_in;
   logic [hfd_pkg::LEN_W-1:0]   cnt_ff, cnt_in;
   logic [hfd_pkg::CODE_W-1:0]  bits_ff, bits_in;
   logic [hfd_pkg::SYM_W-1:0]   sym_ff, sym_in;
   logic                        at_root_ff, at_root_in;
   logic                        chk_ff, chk_in;
   hfd_pkg::result_type         pend_ff, pend_in;
   logic                        pend_vld_ff, pend_vld_in;
   logic                        out_vld_ff, out_vld_in;
   hfd_pkg::result_type         out_res_ff, out_res_in;
   logic                        out_last_ff, out_last_in;

   // shared decisions
   hfd_pkg::cmd_type            cmd;
   hfd_pkg::entry_type          ent;
   logic                        accept;
   logic                        bit_d;
   logic [hfd_pkg::ADDR_W-1:0]  link;
   logic                        link_zero;
   logic                        leaf;
   logic                        len_bad;
   logic                        tree_full;
   logic                        branch_bad;
   logic [hfd_pkg::SHIFT_W-1:0] code_shift;
   hfd_pkg::result_type         res_ok;

   // port decode
   assign accept = start && !busy;
   assign busy   = (state_ff != hfd_pkg::ST_IDLE);
   assign cmd    = hfd_pkg::cmd_type'(req_command);
   assign res_ok = '{sym: '0, valid: 1'b0, err: hfd_pkg::ERR_NONE};

   // current node entry: root from flip-flops, others from memory
   assign ent = at_root_ff ?
                hfd_pkg::entry_type'{sym: '0, right: root_ff.right, left: root_ff.left} :
                rdata_ff;
   assign bit_d     = bits_ff[hfd_pkg::CODE_W-1];
   assign link      = bit_d ? ent.right : ent.left;
   assign link_zero = (link == '0);
   assign leaf      = (ent.right == '0) && (ent.left == '0);

   // range checks
   assign len_bad    = (req_code_length == '0) ||
                       (req_code_length > hfd_pkg::LEN_W'(hfd_pkg::MAX_CODE_LEN));
   assign tree_full  = (hfd_pkg::FIT_W'(nu_ff) + hfd_pkg::FIT_W'(cnt_ff)) >
                       hfd_pkg::FIT_W'(hfd_pkg::NODE_DEPTH);
   assign branch_bad = link_zero || (hfd_pkg::USED_W'(link) >= nu_ff);
   assign code_shift = hfd_pkg::SHIFT_W'(hfd_pkg::LEN_W'(hfd_pkg::CODE_W) - req_code_length);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hfd_pkg::ST_IDLE: begin
            if (accept) begin
               case (cmd)
                  hfd_pkg::CMD_ADD:    state_in = len_bad ? hfd_pkg::ST_DONE
                                                          : hfd_pkg::ST_WALK;
                  hfd_pkg::CMD_DECODE: state_in = hfd_pkg::ST_DECODE;
                  default:             state_in = hfd_pkg::ST_DONE;
               endcase
            end
         end
         hfd_pkg::ST_WALK: begin
            if (cnt_ff == '0) begin
               state_in = hfd_pkg::ST_DONE;
            end else if (link_zero) begin
               state_in = tree_full ? hfd_pkg::ST_DONE : hfd_pkg::ST_MAKE;
            end
         end
         hfd_pkg::ST_MAKE: begin
            if (cnt_ff == '0) state_in = hfd_pkg::ST_DONE;
         end
         hfd_pkg::ST_DECODE: begin
            if (!(chk_ff && leaf) && ((cnt_ff == '0) || branch_bad)) begin
               state_in = hfd_pkg::ST_DONE;
            end
         end
         hfd_pkg::ST_DONE: state_in = hfd_pkg::ST_IDLE;
         default:          state_in = hfd_pkg::ST_IDLE;
      endcase
   end

   // datapath, memory access and results
   always_comb begin
      nu_in       = nu_ff;
      cur_in      = cur_ff;
      walk_in     = walk_ff;
      root_in     = root_ff;
      cnt_in      = cnt_ff;
      bits_in     = bits_ff;
      sym_in      = sym_ff;
      at_root_in  = at_root_ff;
      chk_in      = chk_ff;
      pend_in     = pend_ff;
      pend_vld_in = pend_vld_ff;
      out_vld_in  = 1'b0;
      out_res_in  = pend_ff;
      out_last_in = 1'b0;
      raddr       = cur_ff;
      wr_en       = 1'b0;
      waddr       = walk_ff;
      wdata       = ent;

      case (state_ff)
         hfd_pkg::ST_IDLE: begin
            if (accept) begin
               pend_in     = res_ok;
               pend_vld_in = 1'b1;
               case (cmd)
                  hfd_pkg::CMD_CLEAR: begin
                     nu_in   = hfd_pkg::USED_W'(1);
                     cur_in  = '0;
                     root_in = '0;
                  end
                  hfd_pkg::CMD_ADD: begin
                     sym_in     = req_symbol;
                     cnt_in     = req_code_length;
                     bits_in    = req_code_bits << code_shift;
                     walk_in    = '0;
                     at_root_in = 1'b1;
                     if (len_bad) begin
                        pend_in.err = hfd_pkg::ERR_LENGTH;
                     end else begin
                        pend_vld_in = 1'b0;
                     end
                  end
                  hfd_pkg::CMD_DECODE: begin
                     cnt_in      = (req_bit_count > hfd_pkg::BCNT_W'(hfd_pkg::DATA_W)) ?
                                   hfd_pkg::LEN_W'(hfd_pkg::DATA_W) :
                                   hfd_pkg::LEN_W'(req_bit_count);
                     bits_in     = {req_data_byte, {(hfd_pkg::CODE_W-hfd_pkg::DATA_W){1'b0}}};
                     raddr       = cur_ff;
                     at_root_in  = (cur_ff == '0);
                     chk_in      = 1'b0;
                     pend_vld_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // follow the path, then hang the first new node, set the symbol or flag a full tree
         hfd_pkg::ST_WALK: begin
            if (cnt_ff == '0) begin
               wr_en       = 1'b1;
               waddr       = walk_ff;
               wdata       = '{sym: sym_ff, right: ent.right, left: ent.left};
               pend_in     = res_ok;
               pend_vld_in = 1'b1;
            end else if (!link_zero) begin
               walk_in    = link;
               raddr      = link;
               at_root_in = 1'b0;
               cnt_in     = cnt_ff - 1'b1;
               bits_in    = bits_ff << 1;
            end else if (tree_full) begin
               pend_in     = '{sym: '0, valid: 1'b0, err: hfd_pkg::ERR_FULL};
               pend_vld_in = 1'b1;
            end else begin
               wr_en  = 1'b1;
               waddr  = walk_ff;
               wdata  = ent;
               if (bit_d) wdata.right = hfd_pkg::ADDR_W'(nu_ff);
               else       wdata.left  = hfd_pkg::ADDR_W'(nu_ff);
               cnt_in  = cnt_ff - 1'b1;
               bits_in = bits_ff << 1;
            end
         end

         // fresh nodes: one write per cycle, the last one holds the symbol
         hfd_pkg::ST_MAKE: begin
            wr_en = 1'b1;
            waddr = hfd_pkg::ADDR_W'(nu_ff);
            nu_in = nu_ff + 1'b1;
            if (cnt_ff == '0) begin
               wdata       = '{sym: sym_ff, right: '0, left: '0};
               pend_in     = res_ok;
               pend_vld_in = 1'b1;
            end else begin
               wdata = '0;
               if (bit_d) wdata.right = hfd_pkg::ADDR_W'(nu_ff + 1'b1);
               else       wdata.left  = hfd_pkg::ADDR_W'(nu_ff + 1'b1);
               cnt_in  = cnt_ff - 1'b1;
               bits_in = bits_ff << 1;
            end
         end

         // one bit per cycle, but a reached leaf takes a step of its own to return to the root
         hfd_pkg::ST_DECODE: begin
            if (chk_ff && leaf) begin
               out_vld_in  = pend_vld_ff;
               pend_in     = '{sym: ent.sym, valid: 1'b1, err: hfd_pkg::ERR_NONE};
               pend_vld_in = 1'b1;
               cur_in      = '0;
               at_root_in  = 1'b1;
               chk_in      = 1'b0;
            end else if (cnt_ff == '0) begin
               // nothing left, results drain in the done state
            end else if (branch_bad) begin
               out_vld_in  = pend_vld_ff;
               pend_in     = '{sym: '0, valid: 1'b0, err: hfd_pkg::ERR_BRANCH};
               pend_vld_in = 1'b1;
               cur_in      = '0;
            end else begin
               cur_in     = link;
               raddr      = link;
               at_root_in = 1'b0;
               chk_in     = 1'b1;
               cnt_in     = cnt_ff - 1'b1;
               bits_in    = bits_ff << 1;
            end
         end

         // last result of the transaction
         hfd_pkg::ST_DONE: begin
            out_vld_in  = 1'b1;
            out_res_in  = pend_vld_ff ? pend_ff : res_ok;
            out_last_in = 1'b1;
            pend_vld_in = 1'b0;
         end

         default: begin
         end
      endcase

      // root links follow every write to node zero
      if (wr_en && (waddr == '0)) begin
         root_in = '{right: wdata.right, left: wdata.left};
      end
   end

   // node memory: one write and one registered read per cycle; walks read and
   // builds write, and an add uses no read data once it has begun writing
   always_ff @(posedge clock) begin
      if (wr_en) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= hfd_pkg::ST_IDLE;
         nu_ff       <= hfd_pkg::USED_W'(1);
         cur_ff      <= '0;
         root_ff     <= '0;
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         nu_ff       <= nu_in;
         cur_ff      <= cur_in;
         root_ff     <= root_in;
         pend_vld_ff <= pend_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      walk_ff     <= walk_in;
      cnt_ff      <= cnt_in;
      bits_ff     <= bits_in;
      sym_ff      <= sym_in;
      at_root_ff  <= at_root_in;
      chk_ff      <= chk_in;
      pend_ff     <= pend_in;
      out_res_ff  <= out_vld_in ? out_res_in : '0;
      out_last_ff <= out_last_in;
   end

   // result ports
   assign rsp_strobe         = out_vld_ff;
   assign rsp_decoded_symbol = out_res_ff.sym;
   assign rsp_symbol_valid   = out_res_ff.valid;
   assign rsp_last_of_item   = out_last_ff;
   assign rsp_error_code     = out_res_ff.err;

`ifndef SYNTH
   // node count stays between the root alone and a full table
   a_nodes_range: assert property (@(posedge clock) disable iff (reset)
      (nu_ff != '0) && (nu_ff <= hfd_pkg::USED_W'(hfd_pkg::NODE_DEPTH)))
      else $error("node count out of range");

   // the final result is shown exactly as the controller returns to idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_last_of_item == !busy))
      else $error("last marker does not match end of transaction");

   // any error ends the transaction
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_error_code != hfd_pkg::ERR_NONE)) |-> rsp_last_of_item)
      else $error("error result not marked last");

   // results only come from a transaction in progress
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result without transaction");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Huffman tree decoder. A queue of commands is
// filled up front: a directed set of corner cases, then random rounds that
// mostly load a prefix-free code set and decode an encoded message, plus
// tree-filling rounds and raw noise. A driver feeds the commands with random
// idle bursts, and a monitor predicts every accepted transaction with its own
// tree model and compares each strobed output against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

   // one command as queued for the driver
   typedef struct {
      hfd_pkg::cmd_type           op;
      logic [hfd_pkg::SYM_W-1:0]  sym;
      logic [hfd_pkg::LEN_W-1:0]  len;
      logic [hfd_pkg::CODE_W-1:0] bits;
      logic [hfd_pkg::DATA_W-1:0] data;
      logic [hfd_pkg::BCNT_W-1:0] cnt;
      bit                         drain_first;
   } command_type;

   // one decoder output record
   typedef struct {
      logic [hfd_pkg::SYM_W-1:0] sym;
      logic                      valid;
      logic                      last;
      hfd_pkg::err_type          err;
   } decoder_output_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic [1:0]                   req_command = 2'd0;
   logic [hfd_pkg::SYM_W-1:0]    req_symbol = '0;
   logic [hfd_pkg::LEN_W-1:0]    req_code_length = '0;
   logic [hfd_pkg::CODE_W-1:0]   req_code_bits = '0;
   logic [hfd_pkg::DATA_W-1:0]   req_data_byte = '0;
   logic [hfd_pkg::BCNT_W-1:0]   req_bit_count = '0;
   logic                         rsp_strobe;
   logic [hfd_pkg::SYM_W-1:0]    rsp_decoded_symbol;
   logic                         rsp_symbol_valid;
   logic                         rsp_last_of_item;
   logic [1:0]                   rsp_error_code;

   command_type                  command_queue[$];
   decoder_output_type           due_outputs[$];
   int                           mismatch_count = 0;

   // tree model state
   hfd_pkg::entry_type           node_mem[hfd_pkg::NODE_DEPTH];
   int                           nodes_alloc;
   int                           walk_pos;

   // driver state
   logic                         item_taken = 1'b0;
   command_type                  next_cmd;
   int                           gap_left = 0;
   bit                           idle_phase = 1'b1;

   always #10 clock = ~clock;

   huffman_tree_decoder u_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_command        (req_command),
      .req_symbol         (req_symbol),
      .req_code_length    (req_code_length),
      .req_code_bits      (req_code_bits),
      .req_data_byte      (req_data_byte),
      .req_bit_count      (req_bit_count),
      .rsp_strobe         (rsp_strobe),
      .rsp_decoded_symbol (rsp_decoded_symbol),
      .rsp_symbol_valid   (rsp_symbol_valid),
      .rsp_last_of_item   (rsp_last_of_item),
      .rsp_error_code     (rsp_error_code)
   );

   task automatic report_mismatch(input string what);
      if (mismatch_count < 50) $display("[%0t] mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   // empty tree, position at the root
   function automatic void tree_clear();
      foreach (node_mem[i]) node_mem[i] = '0;
      nodes_alloc = 1;
      walk_pos    = 0;
   endfunction

   function automatic int child_of(int node, logic dir);
      return dir ? int'(node_mem[node].right) : int'(node_mem[node].left);
   endfunction

   function automatic decoder_output_type make_output(logic [hfd_pkg::SYM_W-1:0] sym,
                                                      logic valid,
                                                      hfd_pkg::err_type err);
      decoder_output_type o;
      o.sym   = sym;
      o.valid = valid;
      o.last  = 1'b0;
      o.err   = err;
      return o;
   endfunction

   // predict the outputs of one accepted transaction and update the tree
   function automatic void apply_command(hfd_pkg::cmd_type op,
                                         logic [hfd_pkg::SYM_W-1:0] sym,
                                         logic [hfd_pkg::LEN_W-1:0] len,
                                         logic [hfd_pkg::CODE_W-1:0] bits,
                                         logic [hfd_pkg::DATA_W-1:0] data,
                                         logic [hfd_pkg::BCNT_W-1:0] cnt);
      decoder_output_type outs[$];
      hfd_pkg::err_type   err;
      int                 node;
      int                 c;
      int                 needed;
      int                 span;
      logic               d;

      case (op)
         hfd_pkg::CMD_CLEAR: begin
            tree_clear();
            outs.push_back(make_output('0, 1'b0, hfd_pkg::ERR_NONE));
         end
         hfd_pkg::CMD_ADD: begin
            err    = hfd_pkg::ERR_NONE;
            needed = 0;
            node   = 0;
            if (len == 0 || len > hfd_pkg::MAX_CODE_LEN) begin
               err = hfd_pkg::ERR_LENGTH;
            end else begin
               // count the nodes still missing on the path
               for (int j = 0; j < len; j++) begin
                  c = child_of(node, bits[len-1-j]);
                  if (c == 0) begin
                     needed = len - j;
                     break;
                  end
                  node = c;
               end
               if (nodes_alloc + needed > hfd_pkg::NODE_DEPTH) begin
                  err = hfd_pkg::ERR_FULL;
               end else begin
                  // walk again, creating the missing nodes
                  node = 0;
                  for (int j = 0; j < len; j++) begin
                     d = bits[len-1-j];
                     c = child_of(node, d);
                     if (c == 0) begin
                        c = nodes_alloc;
                        nodes_alloc++;
                        node_mem[c] = '0;
                        if (d) node_mem[node].right = c[hfd_pkg::ADDR_W-1:0];
                        else node_mem[node].left = c[hfd_pkg::ADDR_W-1:0];
                     end
                     node = c;
                  end
                  node_mem[node].sym = sym;
               end
            end
            outs.push_back(make_output('0, 1'b0, err));
         end
         hfd_pkg::CMD_DECODE: begin
            span = (cnt > 8) ? 8 : int'(cnt);
            for (int i = 0; i < span; i++) begin
               d = data[7-i];
               c = child_of(walk_pos, d);
               if (c == 0 || c >= nodes_alloc) begin
                  walk_pos = 0;
                  outs.push_back(make_output('0, 1'b0, hfd_pkg::ERR_BRANCH));
                  break;
               end
               walk_pos = c;
               // a leaf emits its symbol and returns to the root
               if (node_mem[c].left == '0 && node_mem[c].right == '0) begin
                  outs.push_back(make_output(node_mem[c].sym, 1'b1, hfd_pkg::ERR_NONE));
                  walk_pos = 0;
               end
            end
            if (outs.size() == 0) outs.push_back(make_output('0, 1'b0, hfd_pkg::ERR_NONE));
         end
         default: begin
            outs.push_back(make_output('0, 1'b0, hfd_pkg::ERR_NONE));
         end
      endcase

      outs[outs.size()-1].last = 1'b1;
      foreach (outs[i]) due_outputs.push_back(outs[i]);
   endfunction

   // command builders, unused fields random
   function automatic command_type random_command();
      command_type c;
      c.op          = hfd_pkg::cmd_type'($urandom_range(0, 3));
      c.sym         = hfd_pkg::SYM_W'($urandom);
      c.len         = hfd_pkg::LEN_W'($urandom);
      c.bits        = $urandom;
      c.data        = hfd_pkg::DATA_W'($urandom);
      c.cnt         = hfd_pkg::BCNT_W'($urandom);
      c.drain_first = 1'b0;
      return c;
   endfunction

   function automatic command_type plain_command(hfd_pkg::cmd_type op);
      command_type c;
      c    = random_command();
      c.op = op;
      return c;
   endfunction

   function automatic command_type add_command(logic [hfd_pkg::SYM_W-1:0] sym,
                                               logic [hfd_pkg::LEN_W-1:0] len,
                                               logic [hfd_pkg::CODE_W-1:0] bits);
      command_type c;
      c      = plain_command(hfd_pkg::CMD_ADD);
      c.sym  = sym;
      c.len  = len;
      c.bits = bits;
      return c;
   endfunction

   function automatic command_type decode_command(logic [hfd_pkg::DATA_W-1:0] data,
                                                  logic [hfd_pkg::BCNT_W-1:0] cnt);
      command_type c;
      c      = plain_command(hfd_pkg::CMD_DECODE);
      c.data = data;
      c.cnt  = cnt;
      return c;
   endfunction

   // driver: present queued commands at the falling edge
   always @(negedge clock) begin
      if (!reset) begin
         if (start && !item_taken) begin
            // hold the current transaction until it is taken
         end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (command_queue.size() == 0 ||
                      (command_queue[0].drain_first && due_outputs.size() != 0)) begin
            start <= 1'b0;
         end else begin
            next_cmd = command_queue.pop_front();
            req_command     <= next_cmd.op;
            req_symbol      <= next_cmd.sym;
            req_code_length <= next_cmd.len;
            req_code_bits   <= next_cmd.bits;
            req_data_byte   <= next_cmd.data;
            req_bit_count   <= next_cmd.cnt;
            start           <= 1'b1;
            // idle bursts in phases, none near the end
            if (command_queue.size() > 40) begin
               if ($urandom_range(0, 19) == 0) idle_phase = !idle_phase;
               if (idle_phase && $urandom_range(0, 2) == 0) gap_left = $urandom_range(1, 15);
            end
         end
      end
   end

   // monitor: check strobed outputs, then predict any accepted transaction
   always @(posedge clock) begin
      decoder_output_type want;
      if (reset) begin
         item_taken <= 1'b0;
      end else begin
         if (rsp_strobe) begin
            if (due_outputs.size() == 0) begin
               report_mismatch($sformatf("unexpected output sym=%02h valid=%0b last=%0b err=%0d",
                                         rsp_decoded_symbol, rsp_symbol_valid,
                                         rsp_last_of_item, rsp_error_code));
            end else begin
               want = due_outputs.pop_front();
               if (rsp_decoded_symbol !== want.sym || rsp_symbol_valid !== want.valid ||
                   rsp_last_of_item !== want.last || rsp_error_code !== want.err) begin
                  report_mismatch({
                     $sformatf("got sym=%02h valid=%0b last=%0b err=%0d, ",
                               rsp_decoded_symbol, rsp_symbol_valid, rsp_last_of_item,
                               rsp_error_code),
                     $sformatf("want sym=%02h valid=%0b last=%0b err=%0d",
                               want.sym, want.valid, want.last, want.err)});
               end
            end
         end
         item_taken <= start && !busy;
         if (start && !busy) begin
            apply_command(hfd_pkg::cmd_type'(req_command), req_symbol, req_code_length,
                          req_code_bits, req_data_byte, req_bit_count);
         end
      end
   end

   // stimulus build, reset and end of run
   initial begin
      command_type                c;
      logic [hfd_pkg::LEN_W-1:0]  code_len[$];
      logic [hfd_pkg::CODE_W-1:0] code_val[$];
      logic [hfd_pkg::SYM_W-1:0]  code_sym[$];
      bit                         stream[$];
      int                         n_codes;
      int                         k;
      int                         b;
      int                         skip;
      int                         take;
      int                         scenario;
      int                         rounds;
      int                         wait_cycles;

      tree_clear();

      // directed: empty tree, length errors, extreme codes, overwrites
      command_queue.push_back(decode_command(8'h00, 4'd8));
      command_queue.push_back(plain_command(hfd_pkg::CMD_NOP));
      command_queue.push_back(add_command(8'h11, 6'd0, $urandom));
      command_queue.push_back(add_command(8'h22, 6'd33, $urandom));
      command_queue.push_back(add_command(8'h33, 6'd63, $urandom));
      command_queue.push_back(add_command(8'hFF, 6'd1, $urandom & 32'hFFFF_FFFE));
      command_queue.push_back(add_command(8'h00, 6'd32, 32'hFFFF_FFFF));
      c = add_command(8'hA5, 6'd1, $urandom & 32'hFFFF_FFFE);
      c.drain_first = 1'b1;
      command_queue.push_back(c);
      command_queue.push_back(add_command(8'h3C, 6'd2, $urandom | 32'h3));
      // eight leaves in one byte, then a long walk down the all-ones path
      command_queue.push_back(decode_command(8'h00, 4'd8));
      command_queue.push_back(decode_command(8'h80, 4'd1));
      command_queue.push_back(decode_command(hfd_pkg::DATA_W'($urandom), 4'd0));
      command_queue.push_back(decode_command(8'hFF, 4'd15));
      command_queue.push_back(decode_command(8'hFF, 4'd8));
      command_queue.push_back(decode_command(8'hFF, 4'd8));
      command_queue.push_back(decode_command(8'hFF, 4'd8));
      // missing branch on the first bit of a byte, then a short partial byte
      command_queue.push_back(decode_command(8'h3F, 4'd8));
      command_queue.push_back(decode_command(8'h7F, 4'd2));
      command_queue.push_back(plain_command(hfd_pkg::CMD_CLEAR));
      command_queue.push_back(decode_command(8'hAA, 4'd4));
      command_queue.push_back(add_command(8'h5A, 6'd32, 32'h0000_0000));

      // random rounds, the first one loads long random codes
      rounds = 0;
      while (command_queue.size() < 240) begin
         scenario = (rounds == 0) ? 6 : $urandom_range(0, 9);
         rounds++;
         case (scenario)
            0, 1, 2, 3, 4, 5: begin
               // prefix-free code set built by splitting leaves
               c = plain_command(hfd_pkg::CMD_CLEAR);
               c.drain_first = ($urandom_range(0, 3) == 0);
               command_queue.push_back(c);
               code_len = {6'd0};
               code_val = {32'd0};
               code_sym.delete();
               n_codes = $urandom_range(2, 20);
               while (code_len.size() < n_codes) begin
                  k = $urandom_range(0, code_len.size() - 1);
                  if (code_len[k] < 31) begin
                     code_len[k] = code_len[k] + 1'b1;
                     code_val[k] = code_val[k] << 1;
                     code_len.push_back(code_len[k]);
                     code_val.push_back(code_val[k] | 32'd1);
                  end
               end
               // sometimes leave one code out so a branch goes missing
               skip = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n_codes - 1) : -1;
               for (k = 0; k < n_codes; k++) begin
                  code_sym.push_back(hfd_pkg::SYM_W'($urandom));
                  if (k != skip) begin
                     command_queue.push_back(add_command(code_sym[k], code_len[k],
                        code_val[k] | ({$urandom} << code_len[k])));
                  end
               end
               // encoded message, packed MSB first into bytes
               stream.delete();
               repeat ($urandom_range(1, 12)) begin
                  k = $urandom_range(0, n_codes - 1);
                  for (b = code_len[k] - 1; b >= 0; b--) stream.push_back(code_val[k][b]);
               end
               while (stream.size() != 0) begin
                  c = decode_command(hfd_pkg::DATA_W'($urandom), 4'd8);
                  take = (stream.size() < 8) ? stream.size() : 8;
                  for (b = 0; b < take; b++) c.data[7-b] = stream.pop_front();
                  c.cnt = hfd_pkg::BCNT_W'(take);
                  if (take == 8 && $urandom_range(0, 7) == 0)
                     c.cnt = hfd_pkg::BCNT_W'($urandom_range(9, 15));
                  command_queue.push_back(c);
               end
               repeat ($urandom_range(0, 3))
                  command_queue.push_back(decode_command(hfd_pkg::DATA_W'($urandom),
                                          hfd_pkg::BCNT_W'($urandom_range(1, 8))));
            end
            6, 7: begin
               // eighteen long random codes, which may run the node table out
               command_queue.push_back(plain_command(hfd_pkg::CMD_CLEAR));
               repeat (18)
                  command_queue.push_back(add_command(hfd_pkg::SYM_W'($urandom),
                                                      hfd_pkg::LEN_W'($urandom_range(20, 32)),
                                                      $urandom));
               repeat (3)
                  command_queue.push_back(decode_command(hfd_pkg::DATA_W'($urandom), 4'd8));
            end
            default: begin
               repeat (6) command_queue.push_back(random_command());
            end
         endcase
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // wait for all transactions to be taken and all outputs to arrive
      @(negedge clock);
      while (command_queue.size() != 0 || start) @(negedge clock);
      for (wait_cycles = 0; due_outputs.size() != 0 && wait_cycles < 2000; wait_cycles++)
         @(negedge clock);
      repeat (64) @(negedge clock);
      if (due_outputs.size() != 0)
         report_mismatch($sformatf("%0d outputs never arrived", due_outputs.size()));

      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/hfd_pkg.sv
rtl/core/huffman_tree_decoder.sv
tb/tb.sv
